FILE: design/button_toggle_lockout_core_assert.svh
// assertion macros for the button toggle lockout core
`ifndef BUTTON_TOGGLE_LOCKOUT_CORE_ASSERT_SVH
`define BUTTON_TOGGLE_LOCKOUT_CORE_ASSERT_SVH

// checked on every clock edge outside reset
`define BTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/btl_pkg.sv
`timescale 1ns / 1ps

package btl_pkg;

    localparam int NOW_W     = 32;
    localparam int PRESS_W   = 4;
    localparam int FLAGS_W   = 4;
    localparam int MODE_W    = 2;
    localparam int TOGGLE_W  = 3;
    localparam int LOCKOUT_W = 16;
    localparam int WRAP_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 1'd1;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = 16'd200;
    localparam logic [WRAP_W-1:0]    WRAP_RST    = 32'hFFFF_FFFF;

    // button roles and the no-toggle code
    localparam logic [TOGGLE_W-1:0] BTN_DEBUG    = 3'd1;
    localparam logic [TOGGLE_W-1:0] BTN_OVERTAKE = 3'd3;
    localparam logic [TOGGLE_W-1:0] NO_TOGGLE    = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_DRIVE    = 2'd0,
        MODE_DEBUG    = 2'd1,
        MODE_PRACTICE = 2'd2
    } mode_t;

endpackage

FILE: design/btl_if.sv
`timescale 1ns / 1ps

// tick sample channel
interface btl_in_if;
    import btl_pkg::*;

    logic               valid;
    logic               ready;
    logic [NOW_W-1:0]   now_ticks;
    logic [PRESS_W-1:0] pressed;

    modport source (output valid, output now_ticks, output pressed, input ready);
    modport sink   (input valid, input now_ticks, input pressed, output ready);
endinterface

// result channel
interface btl_out_if;
    import btl_pkg::*;

    logic                valid;
    logic                ready;
    logic [FLAGS_W-1:0]  enabled_flags;
    logic [MODE_W-1:0]   display_mode;
    logic                cooling_override;
    logic                send_report;
    logic [TOGGLE_W-1:0] toggled_button;

    modport source (
        output valid, output enabled_flags, output display_mode,
        output cooling_override, output send_report, output toggled_button,
        input ready
    );
    modport sink (
        input valid, input enabled_flags, input display_mode,
        input cooling_override, input send_report, input toggled_button,
        output ready
    );
endinterface

FILE: design/button_toggle_lockout_core.sv
`timescale 1ns / 1ps
// path: an accepted beat is held in the input register, then in the result register (2 registers)
// throughput: one tick sample per cycle while result.ready is high, set by the single input-to-result register pass
// the result register and the input register stall together only when the result is not taken
// reset (rst_n low, asynchronous): press times and enable flags clear, drive mode, no override,
// lockout 200 ticks, wrap at all ones, both channel registers empty
module button_toggle_lockout_core #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    btl_in_if.sink                           sample,
    btl_out_if.source                        result,
    input  logic                             cfg_wr_en,
    input  logic [btl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btl_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);
    import btl_pkg::*;

`include "button_toggle_lockout_core_assert.svh"

    // only the low four buttons can ever be pressed, so only those keep state
    localparam int ACTIVE = (BUTTON_COUNT < PRESS_W) ? BUTTON_COUNT : PRESS_W;

    // configuration registers
    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [WRAP_W-1:0]    wrap_reg;

    // input register stage
    logic               s1_valid_reg;
    logic [NOW_W-1:0]   s1_now_reg;
    logic [PRESS_W-1:0] s1_pressed_reg;

    // per-button state
    logic [NOW_W-1:0]  time_reg [ACTIVE];
    logic [ACTIVE-1:0] en_reg;
    mode_t             mode_reg;
    logic              override_reg;

    // result register
    logic                res_valid_reg;
    logic [FLAGS_W-1:0]  res_flags_reg;
    logic                res_report_reg;
    logic [TOGGLE_W-1:0] res_toggle_reg;

    // next values and pass logic
    logic                s1_adv;
    logic [ACTIVE-1:0]   press_m;
    logic [ACTIVE-1:0]   grant;
    logic                hit;
    logic [NOW_W-1:0]    stored_sel;
    logic [NOW_W-1:0]    fwd_elapsed;
    logic [NOW_W-1:0]    back_diff;
    logic [NOW_W:0]      back_need;
    logic                pass_fwd;
    logic                pass_wrap;
    logic                accept;
    logic [TOGGLE_W-1:0] tog_idx;
    logic [ACTIVE-1:0]   en_next;
    logic [FLAGS_W-1:0]  en_pad;
    logic [FLAGS_W-1:0]  flags_next;
    mode_t               mode_next;
    logic                override_next;
    logic                turn_on;

    // the input register advances whenever the result register is free or being drained
    assign s1_adv       = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_adv;

    // lowest-numbered pressed button wins: isolate the lowest set bit
    assign press_m = s1_pressed_reg[ACTIVE-1:0];
    assign grant   = press_m & (~press_m + ACTIVE'(1));
    assign hit     = |press_m;

    always_comb
    begin
        stored_sel = '0;
        tog_idx    = NO_TOGGLE;
        for (int i = 0; i < ACTIVE; i++)
        begin
            if (grant[i])
            begin
                stored_sel = stored_sel | time_reg[i];
                tog_idx    = TOGGLE_W'(i);
            end
        end
    end

    // elapsed time: plain difference, or wrap minus the backward distance;
    // the wrapped test is wrap > distance + lockout, kept one bit wider to avoid overflow
    assign fwd_elapsed = s1_now_reg - stored_sel;
    assign back_diff   = stored_sel - s1_now_reg;
    assign back_need   = {1'b0, back_diff} + (NOW_W + 1)'(lockout_reg);
    assign pass_fwd    = fwd_elapsed > NOW_W'(lockout_reg);
    assign pass_wrap   = {1'b0, wrap_reg} > back_need;
    assign accept      = hit && ((s1_now_reg >= stored_sel) ? pass_fwd : pass_wrap);

    // flag toggle and the side effects of switching a button on
    assign en_pad  = FLAGS_W'(en_reg);
    assign en_next = accept ? (en_reg ^ grant) : en_reg;
    assign turn_on = accept && ((en_reg & grant) == '0);

    always_comb
    begin
        flags_next             = '0;
        flags_next[ACTIVE-1:0] = en_next;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        override_next = override_reg;
        if (turn_on && (tog_idx == BTN_DEBUG))
        begin
            unique case (mode_reg)
                MODE_DRIVE: mode_next = MODE_DEBUG;
                MODE_DEBUG: mode_next = MODE_PRACTICE;
                default:    mode_next = MODE_DRIVE;
            endcase
        end
        else if (turn_on && (tog_idx == BTN_OVERTAKE) && en_pad[BTN_DEBUG[1:0]])
        begin
            override_next = !override_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= LOCKOUT_RST;
            wrap_reg    <= WRAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOCKOUT: lockout_reg <= cfg_wr_data[LOCKOUT_W-1:0];
                CFG_WRAP:    wrap_reg    <= cfg_wr_data[WRAP_W-1:0];
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_now_reg     <= sample.now_ticks;
            s1_pressed_reg <= sample.pressed;
        end
    end

    // button state, updated as each beat leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                time_reg[i] <= '0;
            end
            en_reg       <= '0;
            mode_reg     <= MODE_DRIVE;
            override_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (accept && grant[i])
                begin
                    time_reg[i] <= s1_now_reg;
                end
            end
            en_reg       <= en_next;
            mode_reg     <= mode_next;
            override_reg <= override_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_flags_reg  <= flags_next;
            res_report_reg <= accept;
            res_toggle_reg <= accept ? tog_idx : NO_TOGGLE;
        end
    end

    // mode and override are state, presented straight with the result beat
    assign result.valid            = res_valid_reg;
    assign result.enabled_flags    = res_flags_reg;
    assign result.display_mode     = mode_reg;
    assign result.cooling_override = override_reg;
    assign result.send_report      = res_report_reg;
    assign result.toggled_button   = res_toggle_reg;

    `BTL_ASSERT(a_report_matches_index,
        res_valid_reg |-> (res_report_reg == (res_toggle_reg != NO_TOGGLE)),
        "send_report disagrees with toggled button")
    `BTL_ASSERT(a_state_holds_on_stall,
        !s1_adv |=> ($stable(en_reg) && $stable(mode_reg) && $stable(override_reg)),
        "button state changed without a beat")
    `BTL_ASSERT(a_toggle_flips_flag,
        (s1_adv && accept) |=> (en_reg != $past(en_reg)),
        "accepted press did not flip its flag")
    `BTL_ASSERT_ALWAYS(a_empty_after_reset,
        !rst_n |=> (!res_valid_reg && !s1_valid_reg),
        "channel registers not empty in reset")

endmodule

FILE: tb/btl_lockout_checker.sv
`timescale 1ns / 1ps

module btl_lockout_checker #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    btl_in_if                             sample,
    btl_out_if                            result,
    input  logic                          cfg_wr_en,
    input  logic [btl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btl_pkg::CFG_DAT_W-1:0] cfg_wr_data,
    output int unsigned                   fails,
    output int unsigned                   pending
);
    import btl_pkg::*;

    localparam int MAX_BUTTONS = 16;
    localparam int LIVE = (BUTTON_COUNT < 4) ? BUTTON_COUNT : 4;

    typedef struct packed {
        logic [FLAGS_W-1:0]  flags;
        mode_t               mode;
        logic                cooling;
        logic                report;
        logic [TOGGLE_W-1:0] toggled;
    } knob_state_t;

    logic [NOW_W-1:0]     press_time [MAX_BUTTONS];
    logic [MAX_BUTTONS-1:0] enable_q;
    mode_t                mode_q;
    logic                 cooling_q;
    logic [LOCKOUT_W-1:0] lockout_q;
    logic [WRAP_W-1:0]    wrap_q;
    knob_state_t          knob_queue [$];
    knob_state_t          want;
    int unsigned          beat_no;

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch at result beat %0d: %s got %0d, expected %0d",
                 beat_no, what, got, exp_val);
        fails++;
    endtask

    // wrapped elapsed time, signed and wide so a negative span never passes
    function automatic bit lockout_cleared(input logic [NOW_W-1:0] now,
                                           input logic [NOW_W-1:0] stored);
        longint elapsed;
        if (now >= stored)
            elapsed = longint'({32'h0, now}) - longint'({32'h0, stored});
        else
            elapsed = longint'({32'h0, wrap_q})
                    - (longint'({32'h0, stored}) - longint'({32'h0, now}));
        return elapsed > longint'({48'h0, lockout_q});
    endfunction

    task automatic advance_knobs(input logic [NOW_W-1:0] now, input logic [PRESS_W-1:0] keys);
        int          winner;
        knob_state_t k;
        winner = MAX_BUTTONS;
        k = '0;
        k.toggled = NO_TOGGLE;
        for (int i = LIVE - 1; i >= 0; i--)
            if (keys[i])
                winner = i;
        if (winner < LIVE && lockout_cleared(now, press_time[winner])) begin
            press_time[winner] = now;
            k.toggled = TOGGLE_W'(winner);
            if (enable_q[winner]) begin
                enable_q[winner] = 1'b0;
            end
            else begin
                enable_q[winner] = 1'b1;
                if (winner == int'(BTN_DEBUG)) begin
                    case (mode_q)
                        MODE_DRIVE: mode_q = MODE_DEBUG;
                        MODE_DEBUG: mode_q = MODE_PRACTICE;
                        default:    mode_q = MODE_DRIVE;
                    endcase
                end
                else if (winner == int'(BTN_OVERTAKE) && enable_q[{1'b0, BTN_DEBUG}]) begin
                    cooling_q = ~cooling_q;
                end
            end
        end
        for (int i = 0; i < LIVE; i++)
            k.flags[i] = enable_q[i];
        k.mode    = mode_q;
        k.cooling = cooling_q;
        k.report  = (k.toggled != NO_TOGGLE);
        knob_queue.push_back(k);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_BUTTONS; i++)
                press_time[i] = '0;
            enable_q  = '0;
            mode_q    = MODE_DRIVE;
            cooling_q = 1'b0;
            lockout_q = LOCKOUT_RST;
            wrap_q    = WRAP_RST;
            knob_queue.delete();
            beat_no   = 0;
            fails     = 0;
            pending  <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOCKOUT: lockout_q = cfg_wr_data[LOCKOUT_W-1:0];
                    CFG_WRAP:    wrap_q    = cfg_wr_data[WRAP_W-1:0];
                    default:     ;
                endcase
            end
            // compare before pushing so a stray beat is never matched to a fresh one
            if (result.valid && result.ready) begin
                if (knob_queue.size() == 0) begin
                    report_mismatch("result beats with none pending", 1, 0);
                end
                else begin
                    want = knob_queue.pop_front();
                    if (result.enabled_flags !== want.flags)
                        report_mismatch("enabled_flags", result.enabled_flags, want.flags);
                    if (result.display_mode !== want.mode)
                        report_mismatch("display_mode", result.display_mode, want.mode);
                    if (result.cooling_override !== want.cooling)
                        report_mismatch("cooling_override", result.cooling_override,
                                        want.cooling);
                    if (result.send_report !== want.report)
                        report_mismatch("send_report", result.send_report, want.report);
                    if (result.toggled_button !== want.toggled)
                        report_mismatch("toggled_button", result.toggled_button,
                                        want.toggled);
                end
                beat_no++;
            end
            if (sample.valid && sample.ready)
                advance_knobs(sample.now_ticks, sample.pressed);
            pending <= knob_queue.size();
        end
    end

endmodule

FILE: tb/button_toggle_lockout_core_test.sv
`timescale 1ns / 1ps

module button_toggle_lockout_core_test;
    import btl_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wr_data;

    int unsigned mismatch_count;
    int unsigned beats_in_flight;

    // settings as last written, used only to shape the tick stream
    longint unsigned cur_lockout;
    longint unsigned cur_wrap;
    longint unsigned tick_now;

    // sender burst bookkeeping
    int burst_left;

    btl_in_if  sample_if ();
    btl_out_if result_if ();

    button_toggle_lockout_core #(
        .BUTTON_COUNT(4)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_if),
        .result     (result_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    // watches both channels and the write port, predicts every result beat
    btl_lockout_checker #(
        .BUTTON_COUNT(4)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_if),
        .result     (result_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .fails      (mismatch_count),
        .pending    (beats_in_flight)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("** button_toggle_lockout_core: FAILED **");
        $finish;
    end

    // result side: back-pressure in stretches, each with its own pattern
    initial
    begin
        int   rx_mode;
        int   rx_left;
        int   rx_hold;
        int   rx_tick;
        logic rdy;
        rx_mode = 0;
        rx_left = 0;
        rx_hold = 0;
        rx_tick = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(30, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: rdy = 1'b1;                                  // no stalls at all
                1: rdy = ($urandom_range(0, 9) < 7);            // scattered stalls
                2: rdy = ((rx_tick % 4) != 0);                  // stall whenever rx_tick % 4 is zero
                default:                                        // occasional long stall
                begin
                    if (rx_hold != 0)
                    begin
                        rdy = 1'b0;
                        rx_hold--;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        rx_hold = $urandom_range(1, 20);
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                    end
                end
            endcase
            result_if.ready <= rdy;
        end
    end

    // one beat, held until taken; valid stays high into the next beat
    task automatic send_beat(input logic [NOW_W-1:0] t, input logic [PRESS_W-1:0] keys);
        @(negedge clk);
        sample_if.valid     <= 1'b1;
        sample_if.now_ticks <= t;
        sample_if.pressed   <= keys;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    // valid low for a number of cycles, payload scrambled meanwhile
    task automatic idle_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_if.valid     <= 1'b0;
            sample_if.now_ticks <= $urandom;
            sample_if.pressed   <= PRESS_W'($urandom);
        end
    endtask

    // sender works in bursts with random gaps, some bursts long and gapless
    task automatic feed_tick(input logic [NOW_W-1:0] t, input logic [PRESS_W-1:0] keys);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(60, 150);
            else
                burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_beat(t, keys);
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic drain_results;
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (beats_in_flight != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // new settings for a phase; press times are first pulled back near zero
    // under the full wrap so a small wrap does not lock every button out
    task automatic apply_settings(input longint unsigned lockout, input longint unsigned wrap);
        drain_results();
        repeat (2) @(negedge clk);
        cfg_write(CFG_LOCKOUT, '0);
        cfg_write(CFG_WRAP, WRAP_RST);
        for (int b = 0; b < 4; b++)
            feed_tick('0, PRESS_W'(1) << b);
        drain_results();
        repeat (2) @(negedge clk);
        cfg_write(CFG_LOCKOUT, CFG_DAT_W'(lockout));
        cfg_write(CFG_WRAP, CFG_DAT_W'(wrap));
        cur_lockout = lockout;
        cur_wrap    = wrap;
        tick_now    = 0;
    endtask

    // mostly a running tick count with steps around the lockout,
    // plus idle ticks and noise that breaks the time sequence
    task automatic run_phase(input int beats);
        longint unsigned step;
        int              pick;
        logic [NOW_W-1:0]   t;
        logic [PRESS_W-1:0] keys;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                t    = $urandom;
                keys = PRESS_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       step = $urandom_range(0, 32'(cur_lockout));
                    1:       step = cur_lockout;
                    2:       step = cur_lockout + 1;
                    3:       step = $urandom_range(32'(cur_lockout + 1),
                                                   32'(3 * cur_lockout + 50));
                    4:       step = $urandom_range(0, 3);
                    default: step = $urandom;
                endcase
                tick_now = (tick_now + step) % cur_wrap;
                t = tick_now[NOW_W-1:0];
                if (pick < 14)
                    keys = '0;
                else if (pick < 35)
                    keys = PRESS_W'($urandom_range(1, 15));
                else
                    keys = PRESS_W'(1) << $urandom_range(0, 3);
            end
            feed_tick(t, keys);
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_wr_data         = '0;
        sample_if.valid     = 1'b0;
        sample_if.now_ticks = '0;
        sample_if.pressed   = '0;
        burst_left          = 0;
        cur_lockout         = LOCKOUT_RST;
        cur_wrap            = WRAP_RST;
        tick_now            = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, lockout 200 exclusive, full wrap
        feed_tick(32'd0,    4'b0000);       // nothing pressed
        feed_tick(32'd100,  4'b0001);       // inside lockout
        feed_tick(32'd200,  4'b0001);       // exactly the lockout, still refused
        feed_tick(32'd201,  4'b0001);       // one past, tc on
        feed_tick(32'd402,  4'b1111);       // all pressed, lowest wins, tc off
        feed_tick(32'd500,  4'b0010);       // debug on, drive to debug mode
        feed_tick(32'd800,  4'b1000);       // overtake on with debug on, override on
        feed_tick(32'd1100, 4'b0010);       // debug off, mode holds
        feed_tick(32'd1400, 4'b1000);       // overtake off, override holds
        feed_tick(32'd1700, 4'b1000);       // overtake on with debug off, override holds
        feed_tick(32'd2000, 4'b0010);       // debug on, practice mode
        feed_tick(32'd2300, 4'b0010);
        feed_tick(32'd2600, 4'b0010);       // debug on again, mode back to drive
        feed_tick(32'd2900, 4'b0100);       // marker on
        feed_tick(32'd3200, 4'b1100);       // marker beats overtake
        feed_tick(32'd3500, 4'b1110);       // debug beats the rest
        feed_tick(32'd100,  4'b0100);       // counter wrapped, long span
        feed_tick(32'hFFFF_FFFF, 4'b0001);  // top of the tick range
        feed_tick(32'd5,    4'b0001);       // wrapped span of 5, refused
        feed_tick(32'h0000_0100, 4'b0001);  // wrapped span of 256, taken

        // directed: no lockout, wrap at one, wrapped spans go negative
        drain_results();
        repeat (2) @(negedge clk);
        cfg_write(CFG_LOCKOUT, '0);
        cfg_write(CFG_WRAP, 32'd1);
        feed_tick(32'h8000_0000, 4'b0001);  // forward span, taken
        feed_tick(32'd50,        4'b0001);  // negative wrapped span, refused
        feed_tick(32'h8000_0000, 4'b0001);  // zero span equals zero lockout, refused
        feed_tick(32'h8000_0001, 4'b0001);  // span of one, taken

        // random phases across the setting extremes
        apply_settings(LOCKOUT_RST, WRAP_RST);
        run_phase(260);
        apply_settings(0, WRAP_RST);
        run_phase(260);
        apply_settings(65535, WRAP_RST);
        run_phase(260);
        apply_settings(10, 1000);
        run_phase(300);
        apply_settings(0, 1);
        run_phase(100);
        apply_settings(300, 5000);
        run_phase(300);
        apply_settings($urandom_range(0, 2000), $urandom_range(2000, 32'hFFFF_FFFF));
        run_phase(300);

        // let the last beats come home, then a few quiet cycles
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && beats_in_flight == 0)
            $display("** button_toggle_lockout_core: PASSED **");
        else
            $display("** button_toggle_lockout_core: FAILED **");
        $finish;
    end

endmodule
